// File: rtl/core/tasps_pkg.sv
// Shared types and constants for the three-axis step pulse scheduler.
package tasps_pkg;

  localparam int unsigned POS_BITS = 32;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TICK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } tasps_state_e;

  typedef struct packed {
    logic capture;
    logic tick;
    logic div_step;
    logic div_last;
    logic out_load;
  } tasps_cmd_t;

endpackage

// File: rtl/core/tasps_ctrl.sv
// Sequencer for the scheduler: input handshake, divide count and result handoff.
module tasps_ctrl import tasps_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic       s_axis_tuser,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output tasps_cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);

  tasps_state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             m_valid_q, m_valid_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_d         = '0;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = (s_axis_tuser == REQ_TICK) ? ST_TICK : ST_DIV;
        end
      end
      ST_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // hold the finished result until the output register frees up
        if (!m_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;

endmodule

// File: rtl/core/tasps_dpath.sv
// Per-axis state, bit-serial delay dividers, tick update and result register.
module tasps_dpath import tasps_pkg::*; #(
  parameter int unsigned NUM_AXES  = 3,
  parameter int unsigned STEP_BITS = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned IN_W      = 88,
  parameter int unsigned OUT_W     = 104
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tasps_cmd_t       cmd_i,
  input  logic             req_type_i,
  input  logic [IN_W-1:0]  in_data_i,
  output logic [OUT_W-1:0] out_data_o
);

  localparam int unsigned REM_W    = STEP_BITS + 1;
  localparam int unsigned DIR_LSB  = NUM_AXES * STEP_BITS;
  localparam int unsigned TIME_LSB = NUM_AXES * (STEP_BITS + 1);
  localparam int unsigned POS_LSB  = NUM_AXES;
  localparam int unsigned BUSY_BIT = NUM_AXES * (POS_BITS + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [STEP_BITS-1:0] steps_q   [NUM_AXES];
  logic [TIME_BITS-1:0] delay_q   [NUM_AXES];
  logic [TIME_BITS-1:0] elapsed_q [NUM_AXES];
  logic [POS_BITS-1:0]  pos_q     [NUM_AXES];
  logic [NUM_AXES-1:0]  dir_q;
  logic [NUM_AXES-1:0]  pulse_q;
  logic [REM_W-1:0]     rem_q     [NUM_AXES];
  logic [TIME_BITS-1:0] quo_q     [NUM_AXES];
  logic [TIME_BITS-1:0] total_q;
  logic [OUT_W-1:0]     out_q;

  logic [TIME_BITS-1:0] elapsed_inc [NUM_AXES];
  logic [NUM_AXES-1:0]  fire;
  logic [REM_W-1:0]     trial       [NUM_AXES];
  logic [NUM_AXES-1:0]  trial_ge;
  logic [REM_W-1:0]     rem_d       [NUM_AXES];
  logic [TIME_BITS-1:0] quo_d       [NUM_AXES];
  logic [NUM_AXES-1:0]  busy_vec;
  logic [OUT_W-1:0]     out_d;
  logic                 start_cap;

  assign start_cap = cmd_i.capture && (req_type_i == REQ_START);

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      // saturate, then compare strictly against the delay
      elapsed_inc[a] = (elapsed_q[a] == TIME_MAX) ? elapsed_q[a]
                                                  : elapsed_q[a] + TIME_BITS'(1);
      fire[a]        = (steps_q[a] != '0) && (elapsed_inc[a] > delay_q[a]);
      // one restoring-division bit per cycle
      trial[a]       = {rem_q[a][REM_W-2:0], quo_q[a][TIME_BITS-1]};
      trial_ge[a]    = trial[a] >= {1'b0, steps_q[a]};
      rem_d[a]       = trial_ge[a] ? (trial[a] - {1'b0, steps_q[a]}) : trial[a];
      quo_d[a]       = {quo_q[a][TIME_BITS-2:0], trial_ge[a]};
      busy_vec[a]    = (steps_q[a] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        steps_q[a]   <= '0;
        delay_q[a]   <= '0;
        elapsed_q[a] <= '0;
        pos_q[a]     <= '0;
      end
      dir_q   <= '0;
      pulse_q <= '0;
    end else begin
      if (start_cap) begin
        pulse_q <= '0;
        for (int a = 0; a < NUM_AXES; a++) begin
          steps_q[a]   <= in_data_i[a*STEP_BITS +: STEP_BITS];
          dir_q[a]     <= in_data_i[DIR_LSB + a];
          elapsed_q[a] <= '0;
        end
      end
      if (cmd_i.tick) begin
        pulse_q <= fire;
        for (int a = 0; a < NUM_AXES; a++) begin
          if (fire[a]) begin
            steps_q[a]   <= steps_q[a] - STEP_BITS'(1);
            elapsed_q[a] <= '0;
            pos_q[a]     <= dir_q[a] ? pos_q[a] + POS_BITS'(1) : pos_q[a] - POS_BITS'(1);
          end else begin
            elapsed_q[a] <= elapsed_inc[a];
          end
        end
      end
      if (cmd_i.div_last) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          delay_q[a] <= (steps_q[a] == '0) ? total_q : quo_d[a];
        end
      end
    end
  end

  // divider working registers and result payload need no reset
  always_ff @(posedge clk_i) begin
    if (start_cap) begin
      total_q <= in_data_i[TIME_LSB +: TIME_BITS];
      for (int a = 0; a < NUM_AXES; a++) begin
        rem_q[a] <= '0;
        quo_q[a] <= in_data_i[TIME_LSB +: TIME_BITS];
      end
    end else if (cmd_i.div_step) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        rem_q[a] <= rem_d[a];
        quo_q[a] <= quo_d[a];
      end
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      out_d[a]                             = pulse_q[a];
      out_d[POS_LSB + a*POS_BITS +: POS_BITS] = pos_q[a];
    end
    out_d[BUSY_BIT] = |busy_vec;
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/core/three_axis_step_pulse_scheduler.sv
// Top level of the three-axis step pulse scheduler.
// The input beat carries a kind in s_axis_tuser: a start move loads step counts,
// directions and the move time, a tick advances every axis by one microsecond.
// Every beat returns one result beat with the step pulses, positions and busy flag.
// A tick beat passes through capture, update and load from acceptance to result.
// A start move passes through capture, the division steps and load, paced by the
// per-axis restoring dividers that produce one quotient bit per cycle. One beat
// is in flight at a time; the result register lets the next beat enter while a
// finished result still waits on m_axis_tready.
module three_axis_step_pulse_scheduler import tasps_pkg::*; #(
  parameter int unsigned NUM_AXES  = 3,
  parameter int unsigned STEP_BITS = 16,
  parameter int unsigned TIME_BITS = 32,
  localparam int unsigned IN_RAW   = NUM_AXES * (STEP_BITS + 1) + TIME_BITS,
  localparam int unsigned IN_W     = ((IN_RAW + 7) / 8) * 8,
  localparam int unsigned OUT_RAW  = NUM_AXES * (POS_BITS + 1) + 1,
  localparam int unsigned OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // steps per axis, dir per axis, move_time_us, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  // req_type
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // pulse per axis, position per axis, busy_res, zero fill
  output logic [OUT_W-1:0] m_axis_tdata
);

  tasps_cmd_t cmd;

  tasps_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  tasps_dpath #(
    .NUM_AXES  (NUM_AXES),
    .STEP_BITS (STEP_BITS),
    .TIME_BITS (TIME_BITS),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a beat is still in work");

  a_start_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_START))
      |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("start move finished before its division");

  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work behind it");

endmodule
